FILE: hw/rtl/diode_ring_modulator_defines.svh
`ifndef DIODE_RING_MODULATOR_DEFINES_SVH
`define DIODE_RING_MODULATOR_DEFINES_SVH

// implication in the same cycle, off while reset is high
`define DRM_ASSERT_IMP(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("drm: same-cycle check failed");

// implication in the next cycle, off while reset is high
`define DRM_ASSERT_NXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("drm: next-cycle check failed");

// implication in the next cycle, checked through reset as well
`define DRM_ASSERT_NXT_ALL(lbl, clk, pre, post) \
   lbl: assert property (@(posedge clk) (pre) |=> (post)) \
      else $error("drm: next-cycle check failed");

`endif

FILE: hw/rtl/drm_pkg.sv
`default_nettype none

package drm_pkg;

   localparam int unsigned SAMPLE_BITS          = 16;
   localparam int unsigned CURVE_DEPTH_DEFAULT  = 256;
   localparam int unsigned MIX_W                = 17;
   localparam logic [MIX_W-1:0] MIX_FULL        = 17'h10000;

   // diode argument magnitude in 1/2048 V, table entries and diode values in 2^-17 V
   localparam int unsigned MAG_W    = SAMPLE_BITS + 2;
   localparam int unsigned FRAC_W   = 12;
   localparam int unsigned BREAK    = 1 << FRAC_W;
   localparam int unsigned CURVE_W  = 18;
   localparam int unsigned DIODE_W  = MAG_W + 6;
   localparam int unsigned RING_W   = DIODE_W + 1;
   localparam int unsigned WET_W    = MIX_W + 1 + RING_W;
   localparam int unsigned DRY_W    = MIX_W + 1 + SAMPLE_BITS;
   localparam int unsigned ACC_W    = WET_W + 1;
   localparam int unsigned OUT_SHIFT = 22;
   localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (OUT_SHIFT - 1);

   localparam logic [63:0] Q30_ONE   = 64'd1 << 30;
   localparam logic [63:0] Q30_LN2   = 64'd744261118;
   localparam logic [63:0] CURVE_DIV = 64'd5 << 14;

   typedef struct packed {
      logic lead;
      logic tail;
   } stage_en_type;

   // restoring division, elaboration use only
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] q;
      logic [64:0] r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[63:0], num[i]};
         if (r >= {1'b0, den}) begin
            r    = r - {1'b0, den};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // exp(-t), q30
   function automatic logic [63:0] exp_neg_q30(input logic [63:0] t);
      logic [63:0] k;
      logic [63:0] r;
      logic [63:0] term;
      logic [63:0] pos;
      logic [63:0] neg;
      k    = t / Q30_LN2;
      r    = t - k * Q30_LN2;
      term = Q30_ONE;
      pos  = Q30_ONE;
      neg  = '0;
      if (k >= 64'd62) begin
         return '0;
      end
      for (int n = 1; n <= 24; n++) begin
         term = udiv64((term * r) >> 30, 64'(n));
         if (n % 2 == 1) begin
            neg = neg + term;
         end else begin
            pos = pos + term;
         end
      end
      return (pos - neg) >> k;
   endfunction

   // ln(1+u), q30, atanh series
   function automatic logic [63:0] ln1p_q30(input logic [63:0] u);
      logic [63:0] w;
      logic [63:0] w2;
      logic [63:0] term;
      logic [63:0] sum;
      w    = udiv64(u << 30, 2 * Q30_ONE + u);
      w2   = (w * w) >> 30;
      term = w;
      sum  = '0;
      for (int n = 0; n < 24; n++) begin
         sum  = sum + udiv64(term, 64'(2 * n + 1));
         term = (term * w2) >> 30;
      end
      return 2 * sum;
   endfunction

   // diode curve at 2*i/depth volt, 2^-17 V, rounded to nearest
   function automatic logic [CURVE_W-1:0] curve_entry(input int unsigned i,
                                                      input int unsigned depth);
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] mag;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] q;
      logic        above;
      a     = 64'(i) * 64'd20;
      b     = 64'(depth) * 64'd10;
      above = a > b;
      mag   = above ? a - b : b - a;
      t     = udiv64(mag << 30, 64'(depth));
      s     = ln1p_q30(exp_neg_q30(t)) + (above ? t : 64'd0);
      q     = (s + CURVE_DIV / 2) / CURVE_DIV;
      return q[CURVE_W-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/drm_diode_lane.sv
`default_nettype none

module drm_diode_lane
   import drm_pkg::*;
#(
   parameter int unsigned CURVE_TABLE_DEPTH = CURVE_DEPTH_DEFAULT
) (
   input  wire logic               clock,
   input  wire stage_en_type       en,
   input  wire logic [MAG_W-1:0]   mag,
   input  wire logic               zero,
   output logic      [DIODE_W-1:0] diode
);

   localparam int unsigned IW = $clog2(CURVE_TABLE_DEPTH + 1);
   localparam int unsigned PW = FRAC_W + IW;
   localparam int unsigned PROD_W = CURVE_W + FRAC_W + 2;

   logic [CURVE_W-1:0] rom_w [CURVE_TABLE_DEPTH+1];

   for (genvar g = 0; g <= CURVE_TABLE_DEPTH; g++) begin : g_rom
      localparam logic [CURVE_W-1:0] ENTRY = curve_entry(g, CURVE_TABLE_DEPTH);
      assign rom_w[g] = ENTRY;
   end

   // table lookup stage
   logic [PW-1:0]          pos_w;
   logic [IW-1:0]          idx_w;
   logic [IW-1:0]          idx_next_w;
   logic                   above_ff, above_in;
   logic                   zero_ff;
   logic [CURVE_W-1:0]     lo_ff, lo_in;
   logic signed [CURVE_W:0] diff_ff, diff_in;
   logic [FRAC_W-1:0]      frac_ff, frac_in;
   logic [DIODE_W-1:0]     line_ff, line_in;

   always_comb begin
      pos_w      = PW'(mag[FRAC_W-1:0]) * PW'(CURVE_TABLE_DEPTH);
      idx_w      = pos_w[PW-1:FRAC_W];
      idx_next_w = idx_w + IW'(1);
      above_in   = mag >= MAG_W'(BREAK);
      lo_in      = rom_w[idx_w];
      diff_in    = $signed({1'b0, rom_w[idx_next_w]}) - $signed({1'b0, rom_w[idx_w]});
      frac_in    = pos_w[FRAC_W-1:0];
      line_in    = {mag - MAG_W'(BREAK / 2), 6'b0};
   end

   always_ff @(posedge clock) begin
      if (en.lead) begin
         above_ff <= above_in;
         zero_ff  <= zero;
         lo_ff    <= lo_in;
         diff_ff  <= diff_in;
         frac_ff  <= frac_in;
         line_ff  <= line_in;
      end
   end

   // interpolation stage, quotient truncated toward zero
   logic signed [PROD_W-1:0]  prod_w;
   logic signed [PROD_W-1:0]  prod_adj_w;
   logic signed [DIODE_W-1:0] interp_w;
   logic [DIODE_W-1:0]        diode_ff, diode_in;

   always_comb begin
      prod_w     = diff_ff * $signed({1'b0, frac_ff});
      prod_adj_w = prod_w + (prod_w < 0 ? PROD_W'((1 << FRAC_W) - 1) : PROD_W'(0));
      interp_w   = $signed({{(DIODE_W - CURVE_W){1'b0}}, lo_ff})
                 + DIODE_W'(prod_adj_w[PROD_W-1:FRAC_W]);
      if (above_ff) begin
         diode_in = line_ff;
      end else if (zero_ff) begin
         diode_in = {interp_w[DIODE_W-2:0], 1'b0};
      end else begin
         diode_in = interp_w;
      end
   end

   always_ff @(posedge clock) begin
      if (en.tail) begin
         diode_ff <= diode_in;
      end
   end

   assign diode = diode_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/drm_mix.sv
`default_nettype none

module drm_mix
   import drm_pkg::*;
(
   input  wire logic                          clock,
   input  wire stage_en_type                  en,
   input  wire logic        [MIX_W-1:0]       wet_mix,
   input  wire logic        [DIODE_W-1:0]     diode_a,
   input  wire logic        [DIODE_W-1:0]     diode_b,
   input  wire logic signed [SAMPLE_BITS-1:0] dry_sample,
   output logic signed      [SAMPLE_BITS-1:0] mixed_sample
);

   localparam int unsigned Y_W = ACC_W - OUT_SHIFT;
   localparam logic signed [Y_W-1:0] Y_MAX = Y_W'((1 << (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [Y_W-1:0] Y_MIN = -Y_MAX - Y_W'(1);

   // product stage
   logic [MIX_W-1:0]         w_eff;
   logic signed [RING_W-1:0] ring_w;
   logic signed [WET_W-1:0]  wet_ff, wet_in;
   logic signed [DRY_W-1:0]  dry_ff, dry_in;

   always_comb begin
      w_eff  = (wet_mix > MIX_FULL) ? MIX_FULL : wet_mix;
      ring_w = $signed({1'b0, diode_a}) - $signed({1'b0, diode_b});
      wet_in = $signed({1'b0, w_eff}) * ring_w;
      dry_in = $signed({1'b0, MIX_FULL - w_eff}) * dry_sample;
   end

   always_ff @(posedge clock) begin
      if (en.lead) begin
         wet_ff <= wet_in;
         dry_ff <= dry_in;
      end
   end

   // sum, round half up, saturate
   logic signed [ACC_W-1:0]       acc_w;
   logic signed [Y_W-1:0]         y_w;
   logic signed [SAMPLE_BITS-1:0] out_ff, out_in;

   always_comb begin
      acc_w = ACC_W'(wet_ff) + (ACC_W'(dry_ff) <<< 6) + $signed(ROUND_HALF);
      y_w   = acc_w[ACC_W-1:OUT_SHIFT];
      if (y_w > Y_MAX) begin
         out_in = SAMPLE_BITS'(Y_MAX);
      end else if (y_w < Y_MIN) begin
         out_in = SAMPLE_BITS'(Y_MIN);
      end else begin
         out_in = y_w[SAMPLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en.tail) begin
         out_ff <= out_in;
      end
   end

   assign mixed_sample = out_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/diode_ring_modulator.sv
// Diode ring modulator with wet/dry mix. Each item holds a signal and a carrier
// sample (signed, 1/1024 V per step) and yields one modulated sample. The block
// takes one item per clock cycle while the output is not stalled. Each result
// passes a front stage that forms the two diode arguments, two stages per lane
// that read and interpolate the diode curve table, and two stages that multiply,
// mix, round and saturate. Each stage only stalls when it and all stages after
// it are full, so bubbles are squeezed out. The curve table is a constant built
// at elaboration, so no start-up sweep is needed after reset. wet_mix resets to
// 65536 (fully modulated); values above 65536 act as 65536. Write it only
// while the pipeline is empty.
`default_nettype none

`include "diode_ring_modulator_defines.svh"

module diode_ring_modulator
   import drm_pkg::*;
#(
   parameter int unsigned CURVE_TABLE_DEPTH = CURVE_DEPTH_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [2*SAMPLE_BITS-1:0]     req_tdata,    // carrier_sample in upper half, signal_sample in lower half
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic      [SAMPLE_BITS-1:0]       rsp_tdata,    // modulated_sample
   input  wire logic                         csr_wr_en,
   input  wire logic [MIX_W-1:0]             csr_wr_data
);

   logic [MIX_W-1:0] wet_mix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wet_mix_ff <= MIX_FULL;
      end else if (csr_wr_en) begin
         wet_mix_ff <= csr_wr_data;
      end
   end

   // valid chain, stage 5 is the output register
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;

   always_comb begin
      rdy5 = !v5_ff || rsp_tready;
      rdy4 = !v4_ff || rdy5;
      rdy3 = !v3_ff || rdy4;
      rdy2 = !v2_ff || rdy3;
      rdy1 = !v1_ff || rdy2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_tvalid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
      end
   end

   // front stage: arguments in 1/2048 V, split into magnitude and zero flag
   logic signed [SAMPLE_BITS-1:0] sig_w, car_w;
   logic signed [MAG_W-1:0]       a2_w, b2_w;
   logic [MAG_W-1:0]              mag_a_ff, mag_a_in, mag_b_ff, mag_b_in;
   logic                          zero_a_ff, zero_b_ff;
   logic signed [SAMPLE_BITS-1:0] sig1_ff, sig2_ff, sig3_ff;

   always_comb begin
      sig_w    = req_tdata[SAMPLE_BITS-1:0];
      car_w    = req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
      a2_w     = (MAG_W'(car_w) <<< 1) + MAG_W'(sig_w);
      b2_w     = (MAG_W'(car_w) <<< 1) - MAG_W'(sig_w);
      mag_a_in = a2_w[MAG_W-1] ? MAG_W'(-a2_w) : a2_w;
      mag_b_in = b2_w[MAG_W-1] ? MAG_W'(-b2_w) : b2_w;
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         mag_a_ff  <= mag_a_in;
         mag_b_ff  <= mag_b_in;
         zero_a_ff <= a2_w == '0;
         zero_b_ff <= b2_w == '0;
         sig1_ff   <= sig_w;
      end
      if (rdy2) sig2_ff <= sig1_ff;
      if (rdy3) sig3_ff <= sig2_ff;
   end

   stage_en_type lane_en, mix_en;
   logic [DIODE_W-1:0] diode_a, diode_b;

   assign lane_en = '{lead: rdy2, tail: rdy3};
   assign mix_en  = '{lead: rdy4, tail: rdy5};

   drm_diode_lane #(
      .CURVE_TABLE_DEPTH(CURVE_TABLE_DEPTH)
   ) u_lane_a (
      .clock(clock),
      .en   (lane_en),
      .mag  (mag_a_ff),
      .zero (zero_a_ff),
      .diode(diode_a)
   );

   drm_diode_lane #(
      .CURVE_TABLE_DEPTH(CURVE_TABLE_DEPTH)
   ) u_lane_b (
      .clock(clock),
      .en   (lane_en),
      .mag  (mag_b_ff),
      .zero (zero_b_ff),
      .diode(diode_b)
   );

   logic signed [SAMPLE_BITS-1:0] mixed_w;

   drm_mix u_mix (
      .clock       (clock),
      .en          (mix_en),
      .wet_mix     (wet_mix_ff),
      .diode_a     (diode_a),
      .diode_b     (diode_b),
      .dry_sample  (sig3_ff),
      .mixed_sample(mixed_w)
   );

   assign req_tready = rdy1;
   assign rsp_tvalid = v5_ff;
   assign rsp_tdata  = mixed_w;

   `DRM_ASSERT_IMP(a_stall_only_when_full, clock, reset, !req_tready,
                   v1_ff && v2_ff && v3_ff && v4_ff && v5_ff)
   `DRM_ASSERT_NXT(a_last_stage_lands, clock, reset, v4_ff && rdy5, rsp_tvalid)
   `DRM_ASSERT_NXT(a_out_drains, clock, reset, v5_ff && rsp_tready && !v4_ff, !rsp_tvalid)
   `DRM_ASSERT_NXT_ALL(a_mix_reset, clock, reset, wet_mix_ff == MIX_FULL)

endmodule

`default_nettype wire
